FILE: hdl/atc_pkg.sv
package atc_pkg;

    // fixed field widths
    localparam int ELEM_W    = 32;
    localparam int PROD_W    = 2 * ELEM_W;
    localparam int ACC_W     = PROD_W + 2;
    localparam int IDX_W     = 2;
    localparam int MAT_DEPTH = 12;
    localparam int ADDR_W    = $clog2(MAT_DEPTH);

    // matrix geometry
    localparam logic [IDX_W-1:0] NUM_ROWS  = 2'd3;
    localparam logic [IDX_W-1:0] LAST_ROW  = 2'd2;
    localparam logic [IDX_W-1:0] LAST_COL  = 2'd3;
    localparam logic [IDX_W-1:0] TRANS_COL = 2'd3;
    localparam logic [IDX_W-1:0] TRANS_K   = 2'd3;
    localparam logic [IDX_W-1:0] LAST_K    = 2'd2;

    // command codes
    localparam logic CMD_LOAD    = 1'b0;
    localparam logic CMD_COMPUTE = 1'b1;

    // matrix select codes
    localparam logic MAT_LEFT  = 1'b0;
    localparam logic MAT_RIGHT = 1'b1;

    // controller to datapath
    typedef struct packed {
        logic             wr_left;
        logic             wr_right;
        logic             issue;
        logic             first;
        logic             last_term;
        logic             trans;
        logic             elem_last;
        logic [IDX_W-1:0] row;
        logic [IDX_W-1:0] col;
        logic [IDX_W-1:0] k;
    } atc_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic loaded;
    } atc_stat_t;

endpackage

FILE: hdl/atc_in_if.sv
interface atc_in_if;
    import atc_pkg::*;

    logic                     valid;
    logic                     ready;
    logic                     cmd;
    logic                     which_matrix;
    logic [IDX_W-1:0]         row_index;
    logic [IDX_W-1:0]         col_index;
    logic signed [ELEM_W-1:0] element_value;

    modport source (
        output valid, cmd, which_matrix, row_index, col_index, element_value,
        input  ready
    );

    modport sink (
        input  valid, cmd, which_matrix, row_index, col_index, element_value,
        output ready
    );

endinterface

FILE: hdl/atc_out_if.sv
interface atc_out_if;
    import atc_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [IDX_W-1:0]         out_row;
    logic [IDX_W-1:0]         out_col;
    logic signed [ELEM_W-1:0] out_value;
    logic                     saturated;
    logic                     last;

    modport source (
        output valid, out_row, out_col, out_value, saturated, last,
        input  ready
    );

    modport sink (
        input  valid, out_row, out_col, out_value, saturated, last,
        output ready
    );

endinterface

FILE: hdl/affine_transform_concat.sv
// channel     dir  payload
// cmd_ch      in   cmd, which_matrix, row_index, col_index, element_value
// result_ch   out  out_row, out_col, out_value, saturated, last
//
// a load word is written into its ram as it is accepted; cmd_ch stays ready
// a compute word yields its twelve result words one element at a time: each
// element runs its three or four terms through one shared multiplier fed by
// the registered reads of the two matrix rams, then drains the pipeline
// rst_n clears control only; matrix contents hold nothing until loaded
// a stall on result_ch holds the finished element and pauses the sequence
module affine_transform_concat #(
    parameter int FRAC_BITS  = 16,
    parameter int WORD_WIDTH = 32
) (
    input logic       clk,
    input logic       rst_n,
    atc_in_if.sink    cmd_ch,
    atc_out_if.source result_ch
);
    import atc_pkg::*;

    atc_cmd_t  ctrl;
    atc_stat_t stat;

    atc_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (cmd_ch.valid),
        .in_ready     (cmd_ch.ready),
        .cmd          (cmd_ch.cmd),
        .which_matrix (cmd_ch.which_matrix),
        .row_index    (cmd_ch.row_index),
        .ctrl         (ctrl),
        .stat         (stat)
    );

    atc_datapath #(
        .FRAC_BITS  (FRAC_BITS),
        .WORD_WIDTH (WORD_WIDTH)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .ctrl          (ctrl),
        .stat          (stat),
        .row_index     (cmd_ch.row_index),
        .col_index     (cmd_ch.col_index),
        .element_value (cmd_ch.element_value),
        .result_ch     (result_ch)
    );

endmodule

FILE: hdl/atc_ram.sv
module atc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 12
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // single write port, registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: hdl/atc_datapath.sv
module atc_datapath #(
    parameter int FRAC_BITS  = 16,
    parameter int WORD_WIDTH = 32
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  atc_pkg::atc_cmd_t                ctrl,
    output atc_pkg::atc_stat_t               stat,
    input  logic [atc_pkg::IDX_W-1:0]        row_index,
    input  logic [atc_pkg::IDX_W-1:0]        col_index,
    input  logic signed [atc_pkg::ELEM_W-1:0] element_value,
    atc_out_if.source                        result_ch
);
    import atc_pkg::*;

    localparam logic signed [ACC_W-1:0] MAX_POS =
        {{(ACC_W-WORD_WIDTH+1){1'b0}}, {(WORD_WIDTH-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] MIN_NEG = ~MAX_POS;

    logic [ADDR_W-1:0]        wr_addr;
    logic [ADDR_W-1:0]        left_addr;
    logic [ADDR_W-1:0]        right_addr;
    logic signed [ELEM_W-1:0] left_data;
    logic signed [ELEM_W-1:0] right_data;

    // read stage tags
    logic             rd_valid_reg;
    logic             rd_first_reg;
    logic             rd_last_reg;
    logic             rd_trans_reg;
    logic             rd_elast_reg;
    logic [IDX_W-1:0] rd_row_reg;
    logic [IDX_W-1:0] rd_col_reg;

    // product stage
    logic                     mul_valid_reg;
    logic                     mul_first_reg;
    logic                     mul_last_reg;
    logic                     mul_elast_reg;
    logic [IDX_W-1:0]         mul_row_reg;
    logic [IDX_W-1:0]         mul_col_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [PROD_W-1:0] prod_next;

    // accumulator stage
    logic                    done_reg;
    logic                    acc_elast_reg;
    logic [IDX_W-1:0]        acc_row_reg;
    logic [IDX_W-1:0]        acc_col_reg;
    logic signed [ACC_W-1:0] acc_reg;
    logic signed [ACC_W-1:0] acc_next;
    logic signed [ACC_W-1:0] prod_ext;

    // output word
    logic                     out_valid_reg;
    logic [IDX_W-1:0]         out_row_reg;
    logic [IDX_W-1:0]         out_col_reg;
    logic signed [ELEM_W-1:0] out_value_reg;
    logic                     out_sat_reg;
    logic                     out_last_reg;

    logic                    load_out;
    logic signed [ACC_W-1:0] shifted;
    logic signed [ACC_W-1:0] sat_val;
    logic                    sat_flag;

    // matrix addresses, row-major
    assign wr_addr    = {row_index, col_index};
    assign left_addr  = {ctrl.row, ctrl.k};
    assign right_addr = {(ctrl.trans ? 2'd0 : ctrl.k), ctrl.col};

    atc_ram #(.WIDTH(ELEM_W), .DEPTH(MAT_DEPTH)) u_left_ram (
        .clk     (clk),
        .wr_en   (ctrl.wr_left),
        .wr_addr (wr_addr),
        .wr_data (element_value),
        .rd_addr (left_addr),
        .rd_data (left_data)
    );

    atc_ram #(.WIDTH(ELEM_W), .DEPTH(MAT_DEPTH)) u_right_ram (
        .clk     (clk),
        .wr_en   (ctrl.wr_right),
        .wr_addr (wr_addr),
        .wr_data (element_value),
        .rd_addr (right_addr),
        .rd_data (right_data)
    );

    // one product per cycle while the controller issues terms, translation aligned to product scale
    always_comb
    begin
        if (rd_trans_reg)
        begin
            prod_next = {{(PROD_W-ELEM_W){left_data[ELEM_W-1]}}, left_data} <<< FRAC_BITS;
        end
        else
        begin
            prod_next = left_data * right_data;
        end
    end

    // accumulate at full precision
    assign prod_ext = {{(ACC_W-PROD_W){prod_reg[PROD_W-1]}}, prod_reg};
    assign acc_next = mul_first_reg ? prod_ext : acc_reg + prod_ext;

    // scale back and clip to word range
    assign shifted = acc_reg >>> FRAC_BITS;
    always_comb
    begin
        if (shifted > MAX_POS)
        begin
            sat_val  = MAX_POS;
            sat_flag = 1'b1;
        end
        else if (shifted < MIN_NEG)
        begin
            sat_val  = MIN_NEG;
            sat_flag = 1'b1;
        end
        else
        begin
            sat_val  = shifted;
            sat_flag = 1'b0;
        end
    end

    assign load_out    = done_reg && (!out_valid_reg || result_ch.ready);
    assign stat.loaded = load_out;

    // pipeline control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_valid_reg  <= 1'b0;
            mul_valid_reg <= 1'b0;
            done_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            rd_valid_reg  <= ctrl.issue;
            mul_valid_reg <= rd_valid_reg;
            if (mul_valid_reg && mul_last_reg)
            begin
                done_reg <= 1'b1;
            end
            else if (load_out)
            begin
                done_reg <= 1'b0;
            end
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // pipeline payload
    always_ff @(posedge clk)
    begin
        rd_first_reg <= ctrl.first;
        rd_last_reg  <= ctrl.last_term;
        rd_trans_reg <= ctrl.trans;
        rd_elast_reg <= ctrl.elem_last;
        rd_row_reg   <= ctrl.row;
        rd_col_reg   <= ctrl.col;

        mul_first_reg <= rd_first_reg;
        mul_last_reg  <= rd_last_reg;
        mul_elast_reg <= rd_elast_reg;
        mul_row_reg   <= rd_row_reg;
        mul_col_reg   <= rd_col_reg;
        prod_reg      <= prod_next;

        if (mul_valid_reg)
        begin
            acc_reg       <= acc_next;
            acc_elast_reg <= mul_elast_reg;
            acc_row_reg   <= mul_row_reg;
            acc_col_reg   <= mul_col_reg;
        end

        if (load_out)
        begin
            out_row_reg   <= acc_row_reg;
            out_col_reg   <= acc_col_reg;
            out_value_reg <= sat_val[ELEM_W-1:0];
            out_sat_reg   <= sat_flag;
            out_last_reg  <= acc_elast_reg;
        end
    end

    assign result_ch.valid     = out_valid_reg;
    assign result_ch.out_row   = out_row_reg;
    assign result_ch.out_col   = out_col_reg;
    assign result_ch.out_value = out_value_reg;
    assign result_ch.saturated = out_sat_reg;
    assign result_ch.last      = out_last_reg;

endmodule

FILE: hdl/atc_ctrl.sv
module atc_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               cmd,
    input  logic               which_matrix,
    input  logic [atc_pkg::IDX_W-1:0] row_index,
    output atc_pkg::atc_cmd_t  ctrl,
    input  atc_pkg::atc_stat_t stat
);
    import atc_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ISSUE,
        ST_DRAIN
    } state_t;

    state_t           state_reg;
    state_t           state_next;
    logic [IDX_W-1:0] row_reg;
    logic [IDX_W-1:0] row_next;
    logic [IDX_W-1:0] col_reg;
    logic [IDX_W-1:0] col_next;
    logic [IDX_W-1:0] k_reg;
    logic [IDX_W-1:0] k_next;

    logic accept;
    logic load_ok;
    logic last_term;
    logic last_elem;

    assign in_ready  = (state_reg == ST_IDLE);
    assign accept    = in_valid && in_ready;
    assign load_ok   = accept && (cmd == CMD_LOAD) && (row_index < NUM_ROWS);
    assign last_term = (col_reg == TRANS_COL) ? (k_reg == TRANS_K) : (k_reg == LAST_K);
    assign last_elem = (row_reg == LAST_ROW) && (col_reg == LAST_COL);

    // datapath command word
    always_comb
    begin
        ctrl.wr_left   = load_ok && (which_matrix == MAT_LEFT);
        ctrl.wr_right  = load_ok && (which_matrix == MAT_RIGHT);
        ctrl.issue     = (state_reg == ST_ISSUE);
        ctrl.first     = (k_reg == '0);
        ctrl.last_term = last_term;
        ctrl.trans     = (k_reg == TRANS_K);
        ctrl.elem_last = last_elem;
        ctrl.row       = row_reg;
        ctrl.col       = col_reg;
        ctrl.k         = k_reg;
    end

    // sequencing over elements and terms
    always_comb
    begin
        state_next = state_reg;
        row_next   = row_reg;
        col_next   = col_reg;
        k_next     = k_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && (cmd == CMD_COMPUTE))
                begin
                    row_next   = '0;
                    col_next   = '0;
                    k_next     = '0;
                    state_next = ST_ISSUE;
                end
            end
            ST_ISSUE:
            begin
                if (last_term)
                begin
                    k_next     = '0;
                    state_next = ST_DRAIN;
                end
                else
                begin
                    k_next = k_reg + 2'd1;
                end
            end
            ST_DRAIN:
            begin
                if (stat.loaded)
                begin
                    if (last_elem)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        state_next = ST_ISSUE;
                        if (col_reg == LAST_COL)
                        begin
                            col_next = '0;
                            row_next = row_reg + 2'd1;
                        end
                        else
                        begin
                            col_next = col_reg + 2'd1;
                        end
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            row_reg   <= '0;
            col_reg   <= '0;
            k_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            row_reg   <= row_next;
            col_reg   <= col_next;
            k_reg     <= k_next;
        end
    end

endmodule
